### design/jbce_pkg.sv
// ---------------------------------------------------------------------------
// JPEG block coefficient expander package
// Shared field widths, symbol status codes and controller command types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jbce_pkg;

  localparam int COMP_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int RUN_W      = 6;
  localparam int COEF_W     = 16;
  localparam int COEF_POS_W = 6;
  localparam int SUM_W      = 7;

  localparam logic [STATUS_W-1:0] SYM_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] SYM_EOB  = 2'd1;
  localparam logic [STATUS_W-1:0] SYM_FAIL = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_DC,
    OP_ZERO,
    OP_VALUE
  } jbce_op_t;

  typedef struct packed {
    logic     load;
    jbce_op_t op;
  } jbce_cmd_t;

  typedef struct packed {
    logic is_dc;
    logic is_eob;
    logic dc_bad;
    logic ac_bad;
    logic pos_zero;
    logic pos_last;
    logic run_zero;
    logic out_free;
  } jbce_status_t;

endpackage

`default_nettype wire

### design/jbce_if.sv
// ---------------------------------------------------------------------------
// JPEG block coefficient expander channels
// Valid/ready channels for incoming symbols and outgoing coefficients.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jbce_sym_if;
  logic                              valid;
  logic                              ready;
  logic [jbce_pkg::COMP_W-1:0]       comp_index;
  logic                              is_dc;
  logic [jbce_pkg::STATUS_W-1:0]     sym_status;
  logic [jbce_pkg::RUN_W-1:0]        zero_run;
  logic signed [jbce_pkg::COEF_W-1:0] coef_value;
  logic                              clear_pred;

  modport source (
    output valid, comp_index, is_dc, sym_status, zero_run, coef_value, clear_pred,
    input  ready
  );
  modport sink (
    input  valid, comp_index, is_dc, sym_status, zero_run, coef_value, clear_pred,
    output ready
  );
endinterface

interface jbce_coef_if;
  logic                               valid;
  logic                               ready;
  logic [jbce_pkg::COEF_POS_W-1:0]    coef_pos;
  logic signed [jbce_pkg::COEF_W-1:0] coef_out;
  logic                               block_last;
  logic                               block_error;

  modport source (
    output valid, coef_pos, coef_out, block_last, block_error,
    input  ready
  );
  modport sink (
    input  valid, coef_pos, coef_out, block_last, block_error,
    output ready
  );
endinterface

`default_nettype wire

### design/jpeg_block_coefficient_expander_unit.sv
// ---------------------------------------------------------------------------
// JPEG block coefficient expander
// Expands decoded DC/AC symbols of a block into its coefficients.
// ---------------------------------------------------------------------------
// Each symbol is first accepted into the symbol registers and then yields its
// coefficient or error items one after another: an AC symbol its zero run of
// zeros and then its value, a DC symbol its coefficient (after an error item
// when it closes an unfinished block), and an end-of-block zeros for all the
// remaining positions. The pace is set by the single result register, which is
// loaded with one item per cycle and holds while the output side stalls.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_block_coefficient_expander_unit #(
  parameter int BLOCK_COEFS = 64,
  parameter int COMP_COUNT  = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  jbce_sym_if.sink    sym,
  jbce_coef_if.source coef
);
  import jbce_pkg::*;

  jbce_cmd_t    cmd;
  jbce_status_t st;
  logic         sym_ready;

  assign sym.ready = sym_ready;

  jbce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym.valid),
    .sym_ready (sym_ready),
    .st        (st),
    .cmd       (cmd)
  );

  jbce_dp #(
    .BLOCK_COEFS (BLOCK_COEFS),
    .COMP_COUNT  (COMP_COUNT)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .sym  (sym),
    .coef (coef),
    .cmd  (cmd),
    .st   (st)
  );

endmodule

`default_nettype wire

### design/jbce_ctrl.sv
// ---------------------------------------------------------------------------
// JPEG block coefficient expander controller
// Sequences one symbol at a time into datapath commands, one result per cycle while the output register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jbce_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   sym_valid,
  output logic                        sym_ready,
  input  wire jbce_pkg::jbce_status_t st,
  output jbce_pkg::jbce_cmd_t         cmd
);
  import jbce_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RUN,
    ST_EOB
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (sym_valid && sym_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (st.out_free) begin
          priority if (st.is_dc && !st.pos_zero) begin
            cmd.op = OP_ERR;
          end else if (st.is_dc && st.dc_bad) begin
            cmd.op     = OP_ERR;
            state_next = ST_IDLE;
          end else if (st.is_dc) begin
            cmd.op     = OP_DC;
            state_next = ST_IDLE;
          end else if (st.pos_zero) begin
            cmd.op     = OP_ERR;
            state_next = ST_IDLE;
          end else if (st.is_eob) begin
            cmd.op     = OP_ZERO;
            state_next = st.pos_last ? ST_IDLE : ST_EOB;
          end else if (st.ac_bad) begin
            cmd.op     = OP_ERR;
            state_next = ST_IDLE;
          end else if (st.run_zero) begin
            cmd.op     = OP_VALUE;
            state_next = ST_IDLE;
          end else begin
            cmd.op     = OP_ZERO;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (st.out_free) begin
          if (st.run_zero) begin
            cmd.op     = OP_VALUE;
            state_next = ST_IDLE;
          end else begin
            cmd.op = OP_ZERO;
          end
        end
      end
      ST_EOB: begin
        if (st.out_free) begin
          cmd.op = OP_ZERO;
          if (st.pos_last) begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sym_ready <= 1'b1;
    end else begin
      state     <= state_next;
      sym_ready <= (state_next == ST_IDLE);
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    sym_ready |-> state == ST_IDLE)
    else $error("symbol ready outside idle");

  a_no_op_stalled: assert property (@(posedge clk) disable iff (rst)
    !st.out_free |-> cmd.op == OP_NONE)
    else $error("result issued while output register is full");

endmodule

`default_nettype wire

### design/jbce_dp.sv
// ---------------------------------------------------------------------------
// JPEG block coefficient expander datapath
// Symbol registers, DC predictors, position and run counters, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jbce_dp #(
  parameter int BLOCK_COEFS = 64,
  parameter int COMP_COUNT  = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  jbce_sym_if.sink                  sym,
  jbce_coef_if.source               coef,
  input  wire jbce_pkg::jbce_cmd_t  cmd,
  output jbce_pkg::jbce_status_t    st
);
  import jbce_pkg::*;

  localparam int POS_W = $clog2(BLOCK_COEFS);

  logic [COEF_W-1:0]   pred [COMP_COUNT];
  logic [POS_W-1:0]    pos;
  logic [COMP_W-1:0]   comp;
  logic                is_dc;
  logic [STATUS_W-1:0] status;
  logic [RUN_W-1:0]    run;
  logic [COEF_W-1:0]   value;

  logic [COEF_W-1:0]   pred_sel;
  logic [COEF_W-1:0]   dc_sum;
  logic [SUM_W-1:0]    run_end;
  logic                out_free;
  logic                pos_last;

  always_comb begin
    pred_sel = '0;
    for (int i = 0; i < COMP_COUNT; i++) begin
      if (comp == COMP_W'(i)) begin
        pred_sel = pred[i];
      end
    end
  end

  assign dc_sum   = pred_sel + value;
  assign run_end  = SUM_W'(pos) + SUM_W'(run);
  assign out_free = !coef.valid || coef.ready;
  assign pos_last = (pos == POS_W'(BLOCK_COEFS - 1));

  assign st.is_dc    = is_dc;
  assign st.is_eob   = (status == SYM_EOB);
  assign st.dc_bad   = (status != SYM_OK && status != SYM_EOB)
                       || (32'(comp) >= COMP_COUNT);
  assign st.ac_bad   = (status != SYM_OK) || (run_end >= SUM_W'(BLOCK_COEFS));
  assign st.pos_zero = (pos == '0);
  assign st.pos_last = pos_last;
  assign st.run_zero = (run == '0);
  assign st.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      comp   <= sym.comp_index;
      is_dc  <= sym.is_dc;
      status <= sym.sym_status;
      value  <= sym.coef_value;
    end
    if (cmd.load) begin
      run <= sym.zero_run;
    end else if (cmd.op == OP_ZERO && !st.is_eob) begin
      run <= run - RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        pred[i] <= '0;
      end
    end else if (cmd.load && sym.clear_pred) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        pred[i] <= '0;
      end
    end else if (cmd.op == OP_DC) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        if (comp == COMP_W'(i)) begin
          pred[i] <= dc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      unique case (cmd.op)
        OP_NONE:  pos <= pos;
        OP_ERR:   pos <= '0;
        OP_DC:    pos <= POS_W'(1);
        OP_ZERO,
        OP_VALUE: pos <= pos_last ? '0 : pos + POS_W'(1);
        default:  pos <= pos;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.valid <= 1'b0;
    end else if (cmd.op != OP_NONE) begin
      coef.valid <= 1'b1;
    end else if (coef.ready) begin
      coef.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_ERR: begin
        coef.coef_pos    <= '0;
        coef.coef_out    <= '0;
        coef.block_last  <= 1'b1;
        coef.block_error <= 1'b1;
      end
      OP_DC: begin
        coef.coef_pos    <= '0;
        coef.coef_out    <= dc_sum;
        coef.block_last  <= 1'b0;
        coef.block_error <= 1'b0;
      end
      OP_ZERO: begin
        coef.coef_pos    <= COEF_POS_W'(pos);
        coef.coef_out    <= '0;
        coef.block_last  <= pos_last;
        coef.block_error <= 1'b0;
      end
      OP_VALUE: begin
        coef.coef_pos    <= COEF_POS_W'(pos);
        coef.coef_out    <= value;
        coef.block_last  <= pos_last;
        coef.block_error <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos) < BLOCK_COEFS)
    else $error("coefficient position beyond block end");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    coef.valid && coef.block_error |->
      coef.block_last && coef.coef_pos == '0 && coef.coef_out == '0)
    else $error("malformed error result");

  a_dc_opens: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DC |=> pos == POS_W'(1))
    else $error("DC symbol did not open a block");

endmodule

`default_nettype wire

### test/jpeg_block_coefficient_expander_unit_tb.sv
// ---------------------------------------------------------------------------
// JPEG block coefficient expander testbench
// Feeds DC and AC symbols and checks every coefficient item against a
// behavioral expansion of the same symbols.
// ---------------------------------------------------------------------------
// A short directed sequence covers the edge cases of the symbol stream. Random
// blocks with random content and some noise and broken blocks follow. Both
// channels idle at random, and the output side once holds off for a long time.
`timescale 1ns / 1ps

module jpeg_block_coefficient_expander_unit_tb;
  import jbce_pkg::*;

  localparam int BLOCK_COEFS = 64;
  localparam int COMPONENTS  = 4;
  localparam int RANDOM_SYMBOLS = 320;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 3000;
  localparam logic [STATUS_W-1:0] SYM_RSVD = 2'd3;

  typedef struct packed {
    logic [COMP_W-1:0]   comp;
    logic                dc;
    logic [STATUS_W-1:0] status;
    logic [RUN_W-1:0]    run;
    logic [COEF_W-1:0]   value;
    logic                clr;
  } symbol_t;

  typedef struct packed {
    logic [COEF_POS_W-1:0] pos;
    logic [COEF_W-1:0]     value;
    logic                  last;
    logic                  err;
  } coef_item_t;

  logic clk;
  logic rst;

  jbce_sym_if  sym_bus ();
  jbce_coef_if coef_bus ();

  jpeg_block_coefficient_expander_unit #(
    .BLOCK_COEFS(BLOCK_COEFS),
    .COMP_COUNT(COMPONENTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .sym(sym_bus),
    .coef(coef_bus)
  );

  symbol_t    pending_symbols[$];
  coef_item_t expected_coefs[$];

  logic [COEF_W-1:0] dc_pred[COMPONENTS];
  int open_pos;

  int symbols_queued;
  int symbols_accepted;
  int coef_count;
  int error_items;
  int closed_blocks;
  int error_count;
  int stall_cycles;
  int hold_left;
  bit hold_request;
  bit hold_done;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic symbol_t make_sym(input logic [COMP_W-1:0] comp, input logic dc,
                                       input logic [STATUS_W-1:0] status,
                                       input logic [RUN_W-1:0] run,
                                       input logic [COEF_W-1:0] value, input logic clr);
    symbol_t s;
    s.comp   = comp;
    s.dc     = dc;
    s.status = status;
    s.run    = run;
    s.value  = value;
    s.clr    = clr;
    return s;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(3))
      0: return COEF_W'($signed($urandom_range(16)) - 8);
      1: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic offer(input symbol_t s);
    pending_symbols.push_back(s);
    symbols_queued++;
  endtask

  task automatic push_coef(input int pos, input logic [COEF_W-1:0] value, input logic last,
                           input logic err);
    coef_item_t c;
    c.pos   = COEF_POS_W'(pos);
    c.value = value;
    c.last  = last;
    c.err   = err;
    expected_coefs.push_back(c);
  endtask

  task automatic push_block_error();
    open_pos = 0;
    push_coef(0, '0, 1'b1, 1'b1);
  endtask

  // Expands one accepted symbol into the coefficient items it must produce.
  task automatic expand_symbol(input symbol_t s);
    int p;
    p = open_pos;
    if (s.clr) begin
      foreach (dc_pred[i]) dc_pred[i] = '0;
    end
    if (s.dc) begin
      if (p != 0) push_block_error();
      if ((s.status != SYM_OK && s.status != SYM_EOB) || s.comp >= COMPONENTS) begin
        push_block_error();
        return;
      end
      dc_pred[s.comp] = dc_pred[s.comp] + s.value;
      open_pos = 1;
      push_coef(0, dc_pred[s.comp], 1'b0, 1'b0);
      return;
    end
    if (p == 0 || p >= BLOCK_COEFS) begin
      push_block_error();
      return;
    end
    if (s.status == SYM_EOB) begin
      for (; p < BLOCK_COEFS; p++) push_coef(p, '0, p == BLOCK_COEFS - 1, 1'b0);
      open_pos = 0;
      return;
    end
    if (s.status != SYM_OK || p + int'(s.run) >= BLOCK_COEFS) begin
      push_block_error();
      return;
    end
    for (int r = 0; r < int'(s.run); r++) begin
      push_coef(p, '0, 1'b0, 1'b0);
      p++;
    end
    if (p == BLOCK_COEFS - 1) begin
      open_pos = 0;
      push_coef(p, s.value, 1'b1, 1'b0);
    end else begin
      open_pos = p + 1;
      push_coef(p, s.value, 1'b0, 1'b0);
    end
  endtask

  // Queues one block: mostly well formed, sometimes cut short or broken.
  task automatic queue_block();
    int pos;
    int roll;
    int run;
    logic [STATUS_W-1:0] dc_status;
    pos = 1;
    roll = $urandom_range(99);
    dc_status = (roll < 5) ? (roll < 2 ? SYM_FAIL : SYM_RSVD) :
                (roll < 18) ? SYM_EOB : SYM_OK;
    offer(make_sym(COMP_W'($urandom), 1'b1, dc_status, RUN_W'($urandom), rand_coef(),
                   $urandom_range(9) == 0));
    while (pos < BLOCK_COEFS) begin
      roll = $urandom_range(99);
      if (roll < 18) begin
        offer(make_sym(COMP_W'($urandom), 1'b0, SYM_EOB, RUN_W'($urandom), rand_coef(),
                       $urandom_range(19) == 0));
        break;
      end else if (roll < 21) begin
        case ($urandom_range(3))
          0: offer(make_sym(COMP_W'($urandom), 1'b0, SYM_FAIL, RUN_W'($urandom),
                            rand_coef(), 1'b0));
          1: offer(make_sym(COMP_W'($urandom), 1'b0, SYM_RSVD, RUN_W'($urandom),
                            rand_coef(), 1'b0));
          2: offer(make_sym(COMP_W'($urandom), 1'b0, SYM_OK,
                            RUN_W'($urandom_range(63, BLOCK_COEFS - pos)), rand_coef(),
                            1'b0));
          default: ;
        endcase
        break;
      end else begin
        if ($urandom_range(3) == 0) run = $urandom_range(BLOCK_COEFS - 1 - pos);
        else run = $urandom_range((BLOCK_COEFS - 1 - pos) < 3 ? BLOCK_COEFS - 1 - pos : 3);
        offer(make_sym(COMP_W'($urandom), 1'b0, SYM_OK, RUN_W'(run), rand_coef(),
                       $urandom_range(19) == 0));
        pos += run + 1;
      end
    end
  endtask

  always @(posedge clk) begin : driver
    symbol_t cur;
    symbol_t nxt;
    if (rst) begin
      sym_bus.valid <= 1'b0;
    end else begin
      if (sym_bus.valid && sym_bus.ready) begin
        cur = make_sym(sym_bus.comp_index, sym_bus.is_dc, sym_bus.sym_status,
                       sym_bus.zero_run, sym_bus.coef_value, sym_bus.clear_pred);
        expand_symbol(cur);
        symbols_accepted++;
      end
      if (!sym_bus.valid || sym_bus.ready) begin
        if (pending_symbols.size() > 0 && (steady || $urandom_range(99) >= 38)) begin
          nxt = pending_symbols.pop_front();
          sym_bus.comp_index <= nxt.comp;
          sym_bus.is_dc      <= nxt.dc;
          sym_bus.sym_status <= nxt.status;
          sym_bus.zero_run   <= nxt.run;
          sym_bus.coef_value <= nxt.value;
          sym_bus.clear_pred <= nxt.clr;
          sym_bus.valid      <= 1'b1;
        end else begin
          sym_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    coef_item_t want;
    if (rst) begin
      coef_bus.ready <= 1'b0;
    end else begin
      if (coef_bus.valid && coef_bus.ready) begin
        coef_count++;
        if (coef_bus.block_error) error_items++;
        else if (coef_bus.block_last) closed_blocks++;
        if (expected_coefs.size() == 0) begin
          $display("%0t: unexpected item: pos %0d value %h last %b error %b", $time,
                   coef_bus.coef_pos, coef_bus.coef_out, coef_bus.block_last,
                   coef_bus.block_error);
          error_count++;
        end else begin
          want = expected_coefs.pop_front();
          if (coef_bus.coef_pos !== want.pos || coef_bus.coef_out !== want.value ||
              coef_bus.block_last !== want.last || coef_bus.block_error !== want.err) begin
            $display("%0t: mismatch: expected pos %0d value %h last %b error %b, got pos %0d value %h last %b error %b",
                     $time, want.pos, want.value, want.last, want.err, coef_bus.coef_pos,
                     coef_bus.coef_out, coef_bus.block_last, coef_bus.block_error);
            error_count++;
          end
        end
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        coef_bus.ready <= 1'b0;
      end else begin
        coef_bus.ready <= steady || $urandom_range(99) >= 38;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst) begin
      stall_cycles <= 0;
    end else if ((sym_bus.valid && sym_bus.ready) || (coef_bus.valid && coef_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int directed_count;
    rst = 1'b1;
    sym_bus.valid      = 1'b0;
    sym_bus.comp_index = '0;
    sym_bus.is_dc      = 1'b0;
    sym_bus.sym_status = SYM_OK;
    sym_bus.zero_run   = '0;
    sym_bus.coef_value = '0;
    sym_bus.clear_pred = 1'b0;
    coef_bus.ready     = 1'b0;
    foreach (dc_pred[i]) dc_pred[i] = '0;
    open_pos = 0;
    symbols_queued = 0;
    symbols_accepted = 0;
    coef_count = 0;
    error_items = 0;
    closed_blocks = 0;
    error_count = 0;
    hold_left = 0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // AC symbols with no block open.
    offer(make_sym(2'd1, 1'b0, SYM_OK, 6'd3, 16'h0011, 1'b0));
    offer(make_sym(2'd2, 1'b0, SYM_EOB, 6'd0, 16'h0000, 1'b0));
    // Predictor wrap and a DC that interrupts an open block.
    offer(make_sym(2'd0, 1'b1, SYM_OK, 6'd63, 16'h7FFF, 1'b1));
    offer(make_sym(2'd0, 1'b1, SYM_OK, 6'd0, 16'h0001, 1'b0));
    offer(make_sym(2'd3, 1'b0, SYM_OK, 6'd0, 16'h8000, 1'b0));
    // The run ends exactly on the last coefficient of the block.
    offer(make_sym(2'd0, 1'b0, SYM_OK, 6'd61, 16'hFFFF, 1'b0));
    offer(make_sym(2'd1, 1'b1, SYM_OK, 6'd0, 16'hFFFF, 1'b0));
    offer(make_sym(2'd1, 1'b0, SYM_EOB, 6'd63, 16'h7FFF, 1'b0));
    // DC with end-of-block status counts as a plain DC.
    offer(make_sym(2'd2, 1'b1, SYM_EOB, 6'd0, 16'h8000, 1'b0));
    offer(make_sym(2'd2, 1'b0, SYM_OK, 6'd63, 16'h0005, 1'b0));
    offer(make_sym(2'd3, 1'b1, SYM_FAIL, 6'd0, 16'h1111, 1'b0));
    offer(make_sym(2'd3, 1'b1, SYM_RSVD, 6'd0, 16'h2222, 1'b0));
    offer(make_sym(2'd3, 1'b1, SYM_OK, 6'd0, 16'h1234, 1'b0));
    offer(make_sym(2'd3, 1'b0, SYM_FAIL, 6'd2, 16'h0007, 1'b0));
    offer(make_sym(2'd3, 1'b1, SYM_OK, 6'd0, 16'h0001, 1'b0));
    offer(make_sym(2'd0, 1'b0, SYM_RSVD, 6'd0, 16'h0009, 1'b0));
    offer(make_sym(2'd0, 1'b1, SYM_OK, 6'd0, 16'h0000, 1'b0));
    // A clear carried by an AC symbol.
    offer(make_sym(2'd1, 1'b0, SYM_OK, 6'd0, 16'h7FFF, 1'b1));
    offer(make_sym(2'd1, 1'b0, SYM_OK, 6'd32, 16'hFFFE, 1'b0));
    offer(make_sym(2'd2, 1'b0, SYM_OK, 6'd62, 16'h0003, 1'b0));
    offer(make_sym(2'd1, 1'b1, SYM_OK, 6'd0, 16'h0005, 1'b0));
    offer(make_sym(2'd0, 1'b0, SYM_EOB, 6'd0, 16'h0000, 1'b0));
    directed_count = symbols_queued;

    // The sender waits here until every expected item has come out.
    while (pending_symbols.size() > 0 || sym_bus.valid || expected_coefs.size() > 0)
      @(negedge clk);

    while (symbols_queued < directed_count + RANDOM_SYMBOLS) begin
      if ($urandom_range(9) == 0)
        offer(make_sym(COMP_W'($urandom), 1'($urandom), STATUS_W'($urandom),
                       RUN_W'($urandom), COEF_W'($urandom), $urandom_range(7) == 0));
      else
        queue_block();
    end
    hold_request = 1'b1;

    while (symbols_accepted < directed_count + 110) @(negedge clk);
    steady = 1'b1;
    while (symbols_accepted < directed_count + 200) @(negedge clk);
    steady = 1'b0;

    while (pending_symbols.size() > 0 || sym_bus.valid || expected_coefs.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Run covered %0d symbols, %0d coefficient items, %0d blocks closed normally",
             symbols_accepted, coef_count, closed_blocks);
    $display("and %0d error items.", error_items);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
